### rtl/lars_pkg.sv
// Shared constants and helpers for the Game of Life raster stepper.
package lars_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;

   localparam int CFG_W   = 8;                          // configuration data width
   localparam int IDX_W   = 1;                          // configuration index width
   localparam int COL_W   = $clog2(MAX_WIDTH);          // column counter / row store address
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);     // row counter, runs to height+1
   localparam int POS_W   = 7;                          // out_row / out_col width
   localparam int CMP_W   = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 2;

   localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 8'd100;
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 8'd100;

   localparam logic [CFG_W-1:0] DIM_MIN = 8'd2;

   // Saturate a grid dimension to [2, hi].
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
      logic [CMP_W-1:0] v_ext;
      v_ext = CMP_W'(v);
      if (v < DIM_MIN) begin
         return DIM_MIN;
      end else if (v_ext > CMP_W'(hi)) begin
         return CFG_W'(hi);
      end else begin
         return v;
      end
   endfunction

endpackage

### rtl/lars_if.sv
// Handshake channels of the Game of Life raster stepper: cell input, result, register write.
interface lars_req_if import lars_pkg::*; ();
   logic valid;
   logic ready;
   logic cell_alive;

   modport source (output valid, output cell_alive, input ready);
   modport sink   (input valid, input cell_alive, output ready);
endinterface

interface lars_rsp_if import lars_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             next_alive;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;
   logic             frame_last;

   modport source (output valid, output next_alive, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input next_alive, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

interface lars_csr_if import lars_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/life_automaton_raster_step.sv
// Top level of the Game of Life (B3/S23) raster stepper.
//
// The block takes one cell word per cycle on req_ch and returns next-generation cells on
// rsp_ch, one word per cycle sustained. A frame is grid_width*grid_height cells in raster
// order followed by grid_width+1 padding words whose cell_alive bit is ignored; the result
// for raster index k leaves on the word accepted as input k+grid_width+1, so the first
// grid_width+1 input words produce nothing. Each result carries row, column, the new state
// and frame_last on the final cell, after which the raster counters restart. Cells outside
// the grid count as dead and nothing wraps around. The accepting edge registers the row
// store reads (two 128x1 stores, previous row and the row before it) with the word in the
// window stage, and the output register is loaded from the 3x3 window and the neighbour
// count when that stage advances. A result waiting in the output register does not
// block the next input word; input stalls only when the window stage holds a word that
// emits while the output register is full and not being taken.
// csr_ch is always ready; register 0 is grid_width, register 1 is grid_height, both
// saturated to [2, 128] when used and both meant to be written only between words.
module life_automaton_raster_step import lars_pkg::*; (
   input  logic clock,
   input  logic reset,
   lars_req_if.sink   req_ch,
   lars_rsp_if.source rsp_ch,
   lars_csr_if.sink   csr_ch
);

   // Window stage payload, captured at the accepting edge.
   typedef struct packed {
      logic             alive;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             last;
      logic             top_off;
      logic             bot_off;
      logic             left_off;
      logic             right_off;
      logic [POS_W-1:0] er;
      logic [POS_W-1:0] ec;
   } s1_type;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0] width_cfg_ff, width_cfg_in;
   logic [CFG_W-1:0] height_cfg_ff, height_cfg_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [8:0]       win_ff, win_in;
   logic             s1_valid_ff, s1_valid_in;
   s1_type           s1_ff, s1_in;
   logic             near_rd_ff;
   logic             far_rd_ff;
   logic             far_wr_pend_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_alive_ff;
   logic [POS_W-1:0] out_row_ff;
   logic [POS_W-1:0] out_col_ff;
   logic             out_last_ff;

   logic near_mem [MAX_WIDTH];
   logic far_mem  [MAX_WIDTH];

   // ---------------------------------------------------------------- handshake
   logic accept;
   logic out_free;
   logic s1_adv;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   // A word that emits nothing leaves the window stage even while the output is full.
   assign s1_adv   = s1_valid_ff && (!s1_ff.emit || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept   = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_GRID_WIDTH:  width_cfg_in  = csr_ch.data;
            REG_GRID_HEIGHT: height_cfg_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- raster position
   logic [CFG_W-1:0] w_eff;
   logic [CFG_W-1:0] h_eff;
   logic [COL_W-1:0] col_cur;
   logic             col_nz;
   logic             in_grid;
   logic             row_ge2;
   logic             last;
   logic             col_wrap;
   logic [ROW_W-1:0] er;
   logic [COL_W-1:0] ec;

   always_comb begin
      w_eff   = clamp_dim(width_cfg_ff, MAX_WIDTH);
      h_eff   = clamp_dim(height_cfg_ff, MAX_HEIGHT);
      // Wrap the column if the width shrank under the counter.
      col_cur = (CMP_W'(col_ff) >= CMP_W'(w_eff)) ? '0 : col_ff;
      col_nz  = (col_cur != '0);
      in_grid = (CMP_W'(row_ff) < CMP_W'(h_eff));
      row_ge2 = (row_ff >= ROW_W'(2));
      last    = (CMP_W'(row_ff) >= CMP_W'(h_eff) + CMP_W'(1));
      col_wrap = (CMP_W'(col_cur) + CMP_W'(1) >= CMP_W'(w_eff));

      // Position of the cell centred in the window after this word.
      if (col_nz) begin
         er = row_ff - ROW_W'(1);
         ec = col_cur - COL_W'(1);
      end else begin
         er = row_ge2 ? (row_ff - ROW_W'(2)) : '0;
         ec = COL_W'(w_eff - CFG_W'(1));
      end

      s1_in.alive     = in_grid & req_ch.cell_alive;
      s1_in.col       = col_cur;
      s1_in.emit      = row_ge2 || ((row_ff == ROW_W'(1)) && col_nz);
      s1_in.last      = last;
      s1_in.top_off   = (er == '0);
      s1_in.bot_off   = (CMP_W'(er) + CMP_W'(1) >= CMP_W'(h_eff));
      s1_in.left_off  = (ec == '0);
      s1_in.right_off = (CMP_W'(ec) + CMP_W'(1) >= CMP_W'(w_eff));
      s1_in.er        = POS_W'(er);
      s1_in.ec        = POS_W'(ec);

      // Advance the raster counters; clear them after the closing padding word.
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_cur + COL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- row stores
   // Read both stores at the accepting edge; write the new cell into the near store at
   // once and move the old near bit into the far store on the following edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         near_rd_ff        <= near_mem[col_cur];
         near_mem[col_cur] <= s1_in.alive;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         far_rd_ff <= far_mem[col_cur];
      end
      if (far_wr_pend_ff) begin
         far_mem[s1_ff.col] <= near_rd_ff;
      end
   end

   // ---------------------------------------------------------------- window and rule
   logic [2:0] top, mid, bot;
   logic [2:0] top_m, mid_m, bot_m;
   logic       ctr;
   logic [3:0] cnt;
   logic       nxt;

   always_comb begin
      top    = {far_rd_ff, win_ff[2:1]};
      mid    = {near_rd_ff, win_ff[5:4]};
      bot    = {s1_ff.alive, win_ff[8:7]};
      win_in = s1_adv ? {bot, mid, top} : win_ff;

      // Drop taps that fall outside the grid.
      top_m = s1_ff.top_off ? 3'b000 : top;
      bot_m = s1_ff.bot_off ? 3'b000 : bot;
      ctr   = mid[1];
      mid_m = mid & 3'b101;
      if (s1_ff.left_off) begin
         top_m = top_m & 3'b110;
         mid_m = mid_m & 3'b110;
         bot_m = bot_m & 3'b110;
      end
      if (s1_ff.right_off) begin
         top_m = top_m & 3'b011;
         mid_m = mid_m & 3'b011;
         bot_m = bot_m & 3'b011;
      end

      cnt = '0;
      for (int i = 0; i < 3; i++) begin
         cnt = cnt + 4'(top_m[i]) + 4'(mid_m[i]) + 4'(bot_m[i]);
      end
      nxt = (cnt == 4'd3) || (ctr && (cnt == 4'd2));
   end

   // ---------------------------------------------------------------- stage control
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      if (s1_adv && s1_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff   <= GRID_WIDTH_RST;
         height_cfg_ff  <= GRID_HEIGHT_RST;
         col_ff         <= '0;
         row_ff         <= '0;
         win_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         far_wr_pend_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         width_cfg_ff   <= width_cfg_in;
         height_cfg_ff  <= height_cfg_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         win_ff         <= win_in;
         s1_valid_ff    <= s1_valid_in;
         far_wr_pend_ff <= accept;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload: hold the window stage until the next accept, load the result on advance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_ff.emit) begin
         out_alive_ff <= nxt;
         out_row_ff   <= s1_ff.er;
         out_col_ff   <= s1_ff.ec;
         out_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.next_alive = out_alive_ff;
   assign rsp_ch.out_row    = out_row_ff;
   assign rsp_ch.out_col    = out_col_ff;
   assign rsp_ch.frame_last = out_last_ff;

   // ---------------------------------------------------------------- assertions
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(row_ff) <= CMP_W'(MAX_HEIGHT + 1))
      else $error("row counter ran past the padding rows");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (row_ff == '0) && (col_ff == '0))
      else $error("raster counters not cleared after frame end");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_ff.emit && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a full pipeline");

   a_far_write: assert property (@(posedge clock) disable iff (reset)
      accept |=> far_wr_pend_ff && s1_valid_ff)
      else $error("far row store write not scheduled for accepted word");

endmodule

### bench/life_generation_checker.sv
// Watches all three channels, predicts every next-generation cell and compares.
module life_generation_checker import lars_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lars_req_if         req_ch,
   lars_rsp_if         rsp_ch,
   lars_csr_if         csr_ch,
   output int unsigned mismatch_count,
   output int unsigned cells_in_flight
);

   typedef struct packed {
      logic             next_alive;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } next_cell_type;

   localparam int unsigned SHOWN_MISMATCHES = 10;

   logic             near_row [MAX_WIDTH];
   logic             far_row  [MAX_WIDTH];
   logic [2:0]       win_top, win_mid, win_bot;
   int               row_pos, col_pos;
   logic [CFG_W-1:0] width_reg, height_reg;
   next_cell_type    next_gen_cells [$];

   function automatic int fit_dim(input logic [CFG_W-1:0] raw, input int hi);
      if (raw < 2) return 2;
      if (int'(raw) > hi) return hi;
      return int'(raw);
   endfunction

   // Advance the raster by one word and work out the cell it retires, if any.
   function void predict_next_cell(input logic alive, output bit emit,
                                   output next_cell_type res);
      int         w, h, r, c, er, ec, cnt;
      logic       v, ctr;
      logic [2:0] top, mid, bot;
      w = fit_dim(width_reg, MAX_WIDTH);
      h = fit_dim(height_reg, MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      v = (r < h) ? alive : 1'b0;

      top = {far_row[c], win_top[2:1]};
      mid = {near_row[c], win_mid[2:1]};
      bot = {v, win_bot[2:1]};
      win_top = top;
      win_mid = mid;
      win_bot = bot;
      far_row[c]  = near_row[c];
      near_row[c] = v;

      emit = (r >= 2) || (r == 1 && c >= 1);
      res.last = (r >= h + 1);
      if (c >= 1) begin
         er = r - 1;
         ec = c - 1;
      end else begin
         er = (r >= 2) ? r - 2 : 0;
         ec = w - 1;
      end

      // drop taps that fall outside the grid
      if (er == 0) top = 3'b000;
      if (er + 1 >= h) bot = 3'b000;
      ctr    = mid[1];
      mid[1] = 1'b0;
      if (ec == 0) begin
         top[0] = 1'b0;
         mid[0] = 1'b0;
         bot[0] = 1'b0;
      end
      if (ec + 1 >= w) begin
         top[2] = 1'b0;
         mid[2] = 1'b0;
         bot[2] = 1'b0;
      end
      cnt = $countones({top, mid, bot});
      res.next_alive = (cnt == 3) || (ctr && cnt == 2);
      res.row = POS_W'(er);
      res.col = POS_W'(ec);

      if (res.last) begin
         row_pos = 0;
         col_pos = 0;
      end else if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1) % 256;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   task automatic note_mismatch(input string what, input next_cell_type want,
                                input next_cell_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("%0t mismatch, %s: expected alive=%0d row=%0d col=%0d last=%0d",
                  $realtime, what, want.next_alive, want.row, want.col, want.last);
         $display("   got alive=%0d row=%0d col=%0d last=%0d",
                  got.next_alive, got.row, got.col, got.last);
      end
   endtask

   always @(posedge clock) begin : watch_words
      bit            emit;
      next_cell_type got_word;
      next_cell_type predicted;
      next_cell_type want;
      if (reset) begin
         width_reg  = GRID_WIDTH_RST;
         height_reg = GRID_HEIGHT_RST;
         foreach (near_row[i]) begin
            near_row[i] = 1'b0;
            far_row[i]  = 1'b0;
         end
         win_top = '0;
         win_mid = '0;
         win_bot = '0;
         row_pos = 0;
         col_pos = 0;
         next_gen_cells.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_word = '{next_alive: rsp_ch.next_alive, row: rsp_ch.out_row,
                         col: rsp_ch.out_col, last: rsp_ch.frame_last};
            if (next_gen_cells.size() == 0) begin
               note_mismatch("result word with none expected", '0, got_word);
            end else begin
               want = next_gen_cells.pop_front();
               if (got_word.next_alive != want.next_alive)
                  note_mismatch("next_alive", want, got_word);
               else if (got_word.row != want.row) note_mismatch("out_row", want, got_word);
               else if (got_word.col != want.col) note_mismatch("out_col", want, got_word);
               else if (got_word.last != want.last)
                  note_mismatch("frame_last", want, got_word);
            end
         end
         // A word accepted at this edge still sees the old registers.
         if (req_ch.valid && req_ch.ready) begin
            predict_next_cell(req_ch.cell_alive, emit, predicted);
            if (emit) next_gen_cells = {next_gen_cells, predicted};
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_GRID_WIDTH:  width_reg  = csr_ch.data;
               REG_GRID_HEIGHT: height_reg = csr_ch.data;
               default: ;
            endcase
         end
      end
      cells_in_flight = next_gen_cells.size();
   end

endmodule

### bench/tb.sv
// Stimulus and verdict for the Game of Life stepper; life_generation_checker does the checking.
module tb import lars_pkg::*; ();

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int ITEM_TARGET   = 1250;
   localparam int TAIL_ITEMS    = 150;  // last words of the run go out with no idling
   localparam int SETTLE_CYCLES = 4;    // lets the window stage and output register drain, with margin
   localparam int END_CYCLES    = 8;
   localparam int STALL_LIMIT   = 1000; // cycles with no word moved on any channel
   localparam int FLUSH_GUARD   = 20000;

   logic clock = 1'b0;
   logic reset;

   lars_req_if req_ch ();
   lars_rsp_if rsp_ch ();
   lars_csr_if csr_ch ();

   int unsigned mismatch_count;
   int unsigned cells_in_flight;
   int unsigned items_sent = 0;
   int unsigned frame_ends = 0;
   int          grid_w = 100;
   int          grid_h = 100;
   bit          calm = 1'b0;     // phase without idling on either side
   bit          tail_reached = 1'b0;

   life_automaton_raster_step u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   life_generation_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .mismatch_count  (mismatch_count),
      .cells_in_flight (cells_in_flight)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Count finished generations so a broken frame can be run out to its end.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.frame_last) frame_ends <= frame_ends + 1;
   end

   // Result side: stall in bursts of random length, never in calm phases or the tail.
   initial begin : drive_result_ready
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (!calm && !tail_reached && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one cell word, maybe after an idle burst, and hold it until accepted.
   // Called and returning at a falling edge; valid stays high for a following word.
   task automatic push_cell(input logic alive);
      if (items_sent >= ITEM_TARGET - TAIL_ITEMS) tail_reached = 1'b1;
      if (!calm && !tail_reached && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.cell_alive = alive;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop valid, wait for every predicted cell, then let the pipeline empty.
   task automatic settle_block();
      req_ch.valid = 1'b0;
      while (cells_in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Write both grid registers on an idle block and track the size in use.
   task automatic set_grid(input logic [CFG_W-1:0] width_raw, input logic [CFG_W-1:0] height_raw);
      settle_block();
      write_register(REG_GRID_WIDTH, width_raw);
      write_register(REG_GRID_HEIGHT, height_raw);
      grid_w = (width_raw < 2) ? 2 :
               (int'(width_raw) > MAX_WIDTH) ? MAX_WIDTH : int'(width_raw);
      grid_h = (height_raw < 2) ? 2 :
               (int'(height_raw) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_raw);
   endtask

   // Padding words close the frame; their cell bit is don't-care, so randomize it.
   task automatic push_padding();
      repeat (grid_w + 1) push_cell(1'($urandom_range(0, 1)));
   endtask

   // Send a fixed pattern, first cell in the top bit, then the padding.
   task automatic send_pattern(input logic [15:0] cells);
      for (int i = grid_w * grid_h - 1; i >= 0; i--) push_cell(cells[i]);
      push_padding();
   endtask

   // Send one random generation with the given percentage of live cells.
   task automatic run_generation(input int density);
      repeat (grid_w * grid_h) push_cell($urandom_range(0, 99) < density);
      push_padding();
   endtask

   // Feed words one at a time until the block closes the current frame.
   task automatic flush_to_frame_end();
      int unsigned seen;
      int          guard;
      seen  = frame_ends;
      guard = 0;
      while (frame_ends == seen && guard < FLUSH_GUARD) begin
         push_cell(1'($urandom_range(0, 1)));
         settle_block();
         guard++;
      end
   endtask

   // Mostly small grids, sometimes the saturating codes below the minimum.
   function automatic logic [CFG_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return CFG_W'($urandom_range(2, 10));
      if (roll < 88) return CFG_W'($urandom_range(0, 1));
      return CFG_W'($urandom_range(11, 16));
   endfunction

   initial begin : stimulus
      int phase_no;
      int partial;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cell_alive = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = REG_GRID_WIDTH;
      csr_ch.data       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a full 2x2 block survives, a diagonal pair dies (grid codes
      // below the minimum saturate to 2), and a 3x3 blinker flips over.
      set_grid(8'd2, 8'd2);
      send_pattern(16'b1111);
      set_grid(8'd0, 8'd1);
      send_pattern(16'b1001);
      set_grid(8'd3, 8'd3);
      send_pattern(16'b010_010_010);

      // Random phases: whole generations back to back, with a few frames cut
      // short by a size change on an idle block and then run out to their end.
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         if (phase_no == 2) begin
            // widest row, height code zero
            set_grid(8'd128, 8'd0);
            run_generation($urandom_range(20, 80));
         end else if (phase_no == 5) begin
            // tallest column, width code one, height code saturating from above
            set_grid(8'd1, 8'd255);
            run_generation($urandom_range(20, 80));
         end else if ($urandom_range(0, 99) < 15) begin
            set_grid(pick_dim(), pick_dim());
            partial = $urandom_range(1, grid_w * grid_h + grid_w);
            repeat (partial) push_cell(1'($urandom_range(0, 1)));
            set_grid(pick_dim(), pick_dim());
            flush_to_frame_end();
         end else begin
            set_grid(pick_dim(), pick_dim());
            repeat ($urandom_range(1, 3)) run_generation($urandom_range(0, 100));
         end
         phase_no++;
      end

      // Wait out every predicted cell, then a few more cycles for strays.
      settle_block();
      repeat (END_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && cells_in_flight == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
